// ===== src/lbd_pkg.sv =====
// shared types, constants and register codes for the ladder button debouncer
`timescale 1ns / 1ps

package lbd_pkg;

    // sample, timestamp, duration and event widths
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int EVENT_W  = 4;

    // configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // minimum spacing between accepted samples, in ms
    localparam logic [TIME_W-1:0] SAMPLE_GAP_MS = 32'd10;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_WINDOW_LOW   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_WINDOW_HIGH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_WINDOW_LOW   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_WINDOW_HIGH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TIME    = 4'd7;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_MODE_THRESHOLD = 10'd900;
    localparam logic [SAMPLE_W-1:0] RST_A_WINDOW_LOW   = 10'd400;
    localparam logic [SAMPLE_W-1:0] RST_A_WINDOW_HIGH  = 10'd600;
    localparam logic [SAMPLE_W-1:0] RST_B_WINDOW_LOW   = 10'd150;
    localparam logic [SAMPLE_W-1:0] RST_B_WINDOW_HIGH  = 10'd400;
    localparam logic [DUR_W-1:0]    RST_DEBOUNCE_TIME  = 16'd30;
    localparam logic [DUR_W-1:0]    RST_LONG_TIME      = 16'd700;
    localparam logic [DUR_W-1:0]    RST_REPEAT_TIME    = 16'd150;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE       = 4'd0;
    localparam logic [EVENT_W-1:0] EV_MODE_SHORT = 4'd1;
    localparam logic [EVENT_W-1:0] EV_A_SHORT    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_B_SHORT    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_MODE_LONG  = 4'd4;
    localparam logic [EVENT_W-1:0] EV_A_LONG     = 4'd5;
    localparam logic [EVENT_W-1:0] EV_B_LONG     = 4'd6;
    localparam logic [EVENT_W-1:0] EV_A_REPEAT   = 4'd7;
    localparam logic [EVENT_W-1:0] EV_B_REPEAT   = 4'd8;
    localparam logic [EVENT_W-1:0] EV_MAX        = EV_B_REPEAT;

    // button codes
    typedef enum logic [1:0] {
        BTN_NONE = 2'd0,
        BTN_MODE = 2'd1,
        BTN_A    = 2'd2,
        BTN_B    = 2'd3
    } btn_t;

    // configuration register set
    typedef struct packed {
        logic [SAMPLE_W-1:0] mode_threshold;
        logic [SAMPLE_W-1:0] a_window_low;
        logic [SAMPLE_W-1:0] a_window_high;
        logic [SAMPLE_W-1:0] b_window_low;
        logic [SAMPLE_W-1:0] b_window_high;
        logic [DUR_W-1:0]    debounce_time;
        logic [DUR_W-1:0]    long_time;
        logic [DUR_W-1:0]    repeat_time;
    } cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic              skip;
        btn_t              code;
        logic [TIME_W-1:0] time_ms;
    } qent_t;

endpackage

// ===== src/lbd_if.sv =====
// handshake channel interfaces for samples, events and configuration writes
`timescale 1ns / 1ps

interface lbd_sample_if import lbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, sample_value, time_ms, input ready);
    modport sink   (input valid, sample_value, time_ms, output ready);
endinterface

interface lbd_event_if import lbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;

    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

interface lbd_cfg_if import lbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lbd_front.sv =====
// front end: sample spacing filter and ladder window classification
`timescale 1ns / 1ps

module lbd_front import lbd_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    lbd_sample_if.sink      smp,
    input  cfg_t            cfg,
    output logic            push_valid,
    input  logic            push_ready,
    output qent_t           push_data
);

    logic [TIME_W-1:0] last_accepted_reg;
    logic [TIME_W-1:0] last_accepted_next;
    logic [TIME_W-1:0] gap;
    logic              too_soon;
    logic              accept;
    btn_t              code;

    // handshake passes straight to the queue
    assign smp.ready  = push_ready;
    assign push_valid = smp.valid;
    assign accept     = smp.valid && push_ready;

    // wrapping gap since the last accepted sample
    assign gap      = smp.time_ms - last_accepted_reg;
    assign too_soon = (gap < SAMPLE_GAP_MS);

    // window classification, mode first then A then B
    always_comb
    begin
        if (smp.sample_value > cfg.mode_threshold)
            code = BTN_MODE;
        else if (smp.sample_value > cfg.a_window_low && smp.sample_value <= cfg.a_window_high)
            code = BTN_A;
        else if (smp.sample_value > cfg.b_window_low && smp.sample_value <= cfg.b_window_high)
            code = BTN_B;
        else
            code = BTN_NONE;
    end

    // queue entry
    always_comb
    begin
        push_data.skip    = too_soon;
        push_data.code    = code;
        push_data.time_ms = smp.time_ms;
    end

    // last accepted timestamp
    always_comb
    begin
        last_accepted_next = last_accepted_reg;
        if (accept && !too_soon)
            last_accepted_next = smp.time_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_accepted_reg <= '0;
        else
            last_accepted_reg <= last_accepted_next;
    end

endmodule

// ===== src/lbd_queue.sv =====
// short queue between the classifier and the event logic
`timescale 1ns / 1ps

module lbd_queue import lbd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  qent_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output qent_t pop_data
);

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    // status
    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/lbd_back.sv =====
// back end: debounce, press timing, short press, long press and repeat events
`timescale 1ns / 1ps

module lbd_back import lbd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  qent_t       pop_data,
    lbd_event_if.source evt
);

    btn_t               stable_reg;
    btn_t               stable_next;
    btn_t               cand_reg;
    btn_t               cand_next;
    logic [TIME_W-1:0]  cand_start_reg;
    logic [TIME_W-1:0]  cand_start_next;
    logic [TIME_W-1:0]  press_start_reg;
    logic [TIME_W-1:0]  press_start_next;
    logic [TIME_W-1:0]  deadline_reg;
    logic [TIME_W-1:0]  deadline_next;
    logic               long_done_reg;
    logic               long_done_next;
    logic               ev_valid_reg;
    logic               ev_valid_next;
    logic [EVENT_W-1:0] ev_reg;
    logic [EVENT_W-1:0] ev_next;
    logic [EVENT_W-1:0] ev_calc;
    logic               take;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  held_press;
    logic [TIME_W-1:0]  held_cand;
    logic [TIME_W-1:0]  next_deadline;

    // output register frees up when empty or being taken
    assign pop_ready      = !ev_valid_reg || evt.ready;
    assign take           = pop_valid && pop_ready;
    assign evt.valid      = ev_valid_reg;
    assign evt.event_code = ev_reg;

    // elapsed times, wrapping
    assign now           = pop_data.time_ms;
    assign held_press    = now - press_start_reg;
    assign held_cand     = now - cand_start_reg;
    assign next_deadline = now + TIME_W'(cfg.repeat_time);

    // per sample state update and event selection
    always_comb
    begin
        stable_next      = stable_reg;
        cand_next        = cand_reg;
        cand_start_next  = cand_start_reg;
        press_start_next = press_start_reg;
        deadline_next    = deadline_reg;
        long_done_next   = long_done_reg;
        ev_calc          = EV_NONE;
        if (pop_data.skip)
        begin
            ev_calc = EV_NONE;
        end
        else if (pop_data.code != cand_reg)
        begin
            // new candidate
            cand_next       = pop_data.code;
            cand_start_next = now;
        end
        else if (cand_reg == stable_reg)
        begin
            // button held steady
            if (stable_reg != BTN_NONE)
            begin
                if (!long_done_reg && held_press >= TIME_W'(cfg.long_time))
                begin
                    long_done_next = 1'b1;
                    deadline_next  = next_deadline;
                    case (stable_reg)
                        BTN_MODE: ev_calc = EV_MODE_LONG;
                        BTN_A:    ev_calc = EV_A_LONG;
                        BTN_B:    ev_calc = EV_B_LONG;
                        default:  ev_calc = EV_NONE;
                    endcase
                end
                else if (long_done_reg && now >= deadline_reg)
                begin
                    deadline_next = next_deadline;
                    case (stable_reg)
                        BTN_A:   ev_calc = EV_A_REPEAT;
                        BTN_B:   ev_calc = EV_B_REPEAT;
                        default: ev_calc = EV_NONE;
                    endcase
                end
            end
        end
        else if (held_cand >= TIME_W'(cfg.debounce_time))
        begin
            // candidate becomes stable
            stable_next = cand_reg;
            if (cand_reg != BTN_NONE)
            begin
                press_start_next = now;
                long_done_next   = 1'b0;
            end
            else if (!long_done_reg)
            begin
                case (stable_reg)
                    BTN_MODE: ev_calc = EV_MODE_SHORT;
                    BTN_A:    ev_calc = EV_A_SHORT;
                    BTN_B:    ev_calc = EV_B_SHORT;
                    default:  ev_calc = EV_NONE;
                endcase
            end
        end
    end

    // output register
    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        ev_next       = ev_reg;
        if (take)
        begin
            ev_valid_next = 1'b1;
            ev_next       = ev_calc;
        end
        else if (evt.ready)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= BTN_NONE;
            cand_reg        <= BTN_NONE;
            cand_start_reg  <= '0;
            press_start_reg <= '0;
            deadline_reg    <= '0;
            long_done_reg   <= 1'b0;
            ev_valid_reg    <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
            if (take)
            begin
                stable_reg      <= stable_next;
                cand_reg        <= cand_next;
                cand_start_reg  <= cand_start_next;
                press_start_reg <= press_start_next;
                deadline_reg    <= deadline_next;
                long_done_reg   <= long_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

endmodule

// ===== src/ladder_button_debounce_long_press.sv =====
// top level of the resistor ladder button debouncer with long press and repeat
//
// sample_ch takes one converter sample and its millisecond timestamp per request.
// event_ch returns exactly one event_code per sample request, in order; most are
// zero (no event), others report short press, long press or auto repeat.
// cfg_ch writes one of eight registers per request (index 0..7, higher ignored);
// it is always ready and is meant to be used only while no sample is in flight.
// An accepted sample is stored in the queue; when the output is free the back
// end takes it and loads the output register, from which its event is offered.
// Throughput: one sample per cycle sustained while event_ch does not stall,
// set by the per sample state update in the back end.
// The front end filters and classifies the sample, a two entry queue holds it,
// and the back end updates the debounce state and loads the output register.
// When event_ch stalls, the output register holds, the queue fills, and
// sample_ch ready drops once the queue is full; nothing is lost.
// Reset loads the default thresholds and times, clears all button state and
// empties the queue and the output register.
`timescale 1ns / 1ps

module ladder_button_debounce_long_press import lbd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lbd_sample_if.sink  sample_ch,
    lbd_event_if.source event_ch,
    lbd_cfg_if.sink     cfg_ch
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    qent_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    qent_t pop_data;

    // configuration register file
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_MODE_THRESHOLD: cfg_next.mode_threshold = cfg_ch.data[SAMPLE_W-1:0];
                REG_A_WINDOW_LOW:   cfg_next.a_window_low   = cfg_ch.data[SAMPLE_W-1:0];
                REG_A_WINDOW_HIGH:  cfg_next.a_window_high  = cfg_ch.data[SAMPLE_W-1:0];
                REG_B_WINDOW_LOW:   cfg_next.b_window_low   = cfg_ch.data[SAMPLE_W-1:0];
                REG_B_WINDOW_HIGH:  cfg_next.b_window_high  = cfg_ch.data[SAMPLE_W-1:0];
                REG_DEBOUNCE_TIME:  cfg_next.debounce_time  = cfg_ch.data[DUR_W-1:0];
                REG_LONG_TIME:      cfg_next.long_time      = cfg_ch.data[DUR_W-1:0];
                REG_REPEAT_TIME:    cfg_next.repeat_time    = cfg_ch.data[DUR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_threshold <= RST_MODE_THRESHOLD;
            cfg_reg.a_window_low   <= RST_A_WINDOW_LOW;
            cfg_reg.a_window_high  <= RST_A_WINDOW_HIGH;
            cfg_reg.b_window_low   <= RST_B_WINDOW_LOW;
            cfg_reg.b_window_high  <= RST_B_WINDOW_HIGH;
            cfg_reg.debounce_time  <= RST_DEBOUNCE_TIME;
            cfg_reg.long_time      <= RST_LONG_TIME;
            cfg_reg.repeat_time    <= RST_REPEAT_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classifier
    lbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (sample_ch),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    lbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // event logic
    lbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .evt       (event_ch)
    );

endmodule

// ===== src/lbd_checker.sv =====
// port level checks for the ladder button debouncer and their binding
`timescale 1ns / 1ps

module lbd_checker import lbd_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [EVENT_W-1:0] event_code
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_take;
    logic       out_take;

    // requests in flight between the sample and event channels
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
            pending_next = pending_reg + 1'b1;
        else if (out_take && !in_take)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // an event only for a sample already taken
    a_event_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("event offered with no sample in flight");

    // queue plus output register bound the samples in flight
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more samples in flight than storage allows");

    // event codes stay in the defined set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= EV_MAX)
        else $error("event code out of range");

    // a stalled event stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code))
        else $error("stalled event dropped or changed");

endmodule

bind ladder_button_debounce_long_press lbd_checker u_lbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (event_ch.valid),
    .out_ready  (event_ch.ready),
    .event_code (event_ch.event_code)
);
